@@ design/obt_pkg.sv @@
// Shared types, constants and codes for the order book level tracker.
package obt_pkg;

    localparam int ORDER_SLOTS = 1024;
    localparam int LEVEL_SLOTS = 256;
    localparam int OIDX_W      = $clog2(ORDER_SLOTS);
    localparam int LIDX_W      = $clog2(LEVEL_SLOTS);
    localparam int LADDR_W     = LIDX_W + 1;
    localparam int CLEAR_LEN   = (ORDER_SLOTS > 2 * LEVEL_SLOTS) ? ORDER_SLOTS
                                                                 : 2 * LEVEL_SLOTS;
    localparam int CLR_W       = $clog2(CLEAR_LEN);
    localparam int TOTAL_W     = 41;
    localparam int OCNT_W      = 11;
    localparam int LCNT_W      = 9;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [2:0] MODE_NEW     = 3'd0;
    localparam logic [2:0] MODE_PARTIAL = 3'd1;
    localparam logic [2:0] MODE_EXEC    = 3'd2;
    localparam logic [2:0] MODE_CANCEL  = 3'd3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_NEW    = 2'd1;
    localparam logic [1:0] KIND_REDUCE = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        order_ref;
        logic [30:0]        price;
        logic signed [31:0] size;
        logic               side;
    } in_item_t;

    typedef struct packed {
        logic [10:0] active_orders;
        logic [8:0]  bid_level_count;
        logic [8:0]  ask_level_count;
        logic [10:0] peak_orders;
        logic [8:0]  peak_levels;
        logic        overflow;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] order_ref;
        logic [30:0] price;
        logic [30:0] amount;
        logic        side;
    } cmd_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [30:0] price;
        logic [30:0] remaining;
        logic        side;
    } ord_t;

    typedef struct packed {
        logic               valid;
        logic [30:0]        price;
        logic [TOTAL_W-1:0] total;
        logic [OCNT_W-1:0]  orders;
    } lvl_t;

endpackage

@@ design/obt_front.sv @@
// Front end: accepts message beats, classifies them and queues commands.
module obt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  obt_pkg::in_item_t in_item,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output obt_pkg::cmd_t     cmd
);

    obt_pkg::cmd_t             q_mem [obt_pkg::QDEPTH];
    logic [obt_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [obt_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [obt_pkg::QPTR_W:0]   cnt_reg, cnt_next;
    logic                       push, pop, positive;
    obt_pkg::cmd_t              cls;

    assign in_stall  = (cnt_reg == (obt_pkg::QPTR_W+1)'(obt_pkg::QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        positive      = (in_item.size > 32'sd0);
        cls.order_ref = in_item.order_ref;
        cls.price     = in_item.price;
        cls.amount    = in_item.size[30:0];
        cls.side      = in_item.side;
        case (in_item.mode)
            obt_pkg::MODE_NEW:     cls.kind = positive ? obt_pkg::KIND_NEW : obt_pkg::KIND_NONE;
            obt_pkg::MODE_PARTIAL,
            obt_pkg::MODE_EXEC:    cls.kind = positive ? obt_pkg::KIND_REDUCE
                                                       : obt_pkg::KIND_NONE;
            obt_pkg::MODE_CANCEL:  cls.kind = obt_pkg::KIND_CANCEL;
            default:               cls.kind = obt_pkg::KIND_NONE;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (obt_pkg::QPTR_W+1)'(push) - (obt_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ design/obt_back.sv @@
// Back end: table scans, order and level updates, result register.
module obt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  obt_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_stall,
    output obt_pkg::out_item_t out_item
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_ORD_RD  = 4'd2;
    localparam logic [3:0] S_ORD_CMP = 4'd3;
    localparam logic [3:0] S_ORD_END = 4'd4;
    localparam logic [3:0] S_LVL_RD  = 4'd5;
    localparam logic [3:0] S_LVL_CMP = 4'd6;
    localparam logic [3:0] S_REDUCE  = 4'd7;
    localparam logic [3:0] S_NEW_CHK = 4'd8;
    localparam logic [3:0] S_INSERT  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    localparam int OIDX_W  = obt_pkg::OIDX_W;
    localparam int LIDX_W  = obt_pkg::LIDX_W;
    localparam int LADDR_W = obt_pkg::LADDR_W;
    localparam int OCNT_W  = obt_pkg::OCNT_W;
    localparam int LCNT_W  = obt_pkg::LCNT_W;

    obt_pkg::ord_t ord_mem [obt_pkg::ORDER_SLOTS];
    obt_pkg::lvl_t lvl_mem [2 * obt_pkg::LEVEL_SLOTS];

    obt_pkg::ord_t       ord_rd_reg, ord_wdata;
    obt_pkg::lvl_t       lvl_rd_reg, lvl_wdata;
    logic [OIDX_W-1:0]   ord_raddr, ord_waddr;
    logic [LADDR_W-1:0]  lvl_raddr, lvl_waddr;
    logic                ord_we, lvl_we;

    logic [3:0]          state_reg, state_next;
    logic [obt_pkg::CLR_W-1:0] clr_reg, clr_next;
    obt_pkg::cmd_t       cmd_reg, cmd_next;
    logic [OIDX_W-1:0]   oidx_reg, oidx_next, omatch_reg, omatch_next;
    logic [OIDX_W-1:0]   ofree_reg, ofree_next, slot_reg, slot_next;
    logic                ofound_reg, ofound_next, ofree_found_reg, ofree_found_next;
    obt_pkg::ord_t       oent_reg, oent_next;
    logic [LIDX_W-1:0]   lidx_reg, lidx_next, lmatch_reg, lmatch_next;
    logic [LIDX_W-1:0]   lfree_reg, lfree_next;
    logic                lfound_reg, lfound_next, lfree_found_reg, lfree_found_next;
    obt_pkg::lvl_t       lent_reg, lent_next;
    logic                lside_reg, lside_next, lnew_reg, lnew_next;
    logic [30:0]         lprice_reg, lprice_next;
    logic                ovf_reg, ovf_next;
    logic [OCNT_W-1:0]   live_reg, live_next, peak_ord_reg, peak_ord_next;
    logic [LCNT_W-1:0]   bid_reg, bid_next, ask_reg, ask_next;
    logic [LCNT_W-1:0]   peak_lvl_reg, peak_lvl_next, most;
    logic                out_valid_reg, out_valid_next;
    obt_pkg::out_item_t  out_item_reg, out_item_next;

    logic [30:0]              amt;
    logic [obt_pkg::TOTAL_W-1:0] tot;
    logic [OCNT_W-1:0]        ords;
    logic                     full, empty;
    obt_pkg::lvl_t            base;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign ord_raddr = oidx_reg;
    assign lvl_raddr = {lside_reg, lidx_reg};

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        cmd_next         = cmd_reg;
        oidx_next        = oidx_reg;
        omatch_next      = omatch_reg;
        ofree_next       = ofree_reg;
        slot_next        = slot_reg;
        ofound_next      = ofound_reg;
        ofree_found_next = ofree_found_reg;
        oent_next        = oent_reg;
        lidx_next        = lidx_reg;
        lmatch_next      = lmatch_reg;
        lfree_next       = lfree_reg;
        lfound_next      = lfound_reg;
        lfree_found_next = lfree_found_reg;
        lent_next        = lent_reg;
        lside_next       = lside_reg;
        lnew_next        = lnew_reg;
        lprice_next      = lprice_reg;
        ovf_next         = ovf_reg;
        live_next        = live_reg;
        bid_next         = bid_reg;
        ask_next         = ask_reg;
        peak_ord_next    = peak_ord_reg;
        peak_lvl_next    = peak_lvl_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_item_next    = out_item_reg;
        cmd_pop          = 1'b0;
        ord_we           = 1'b0;
        ord_waddr        = omatch_reg;
        ord_wdata        = oent_reg;
        lvl_we           = 1'b0;
        lvl_waddr        = {lside_reg, lmatch_reg};
        lvl_wdata        = lent_reg;
        most             = (bid_reg > ask_reg) ? bid_reg : ask_reg;

        // reduction arithmetic
        if (cmd_reg.kind == obt_pkg::KIND_REDUCE && cmd_reg.amount < oent_reg.remaining)
            amt = cmd_reg.amount;
        else
            amt = oent_reg.remaining;
        full  = (amt == oent_reg.remaining);
        tot   = lent_reg.total - {{(obt_pkg::TOTAL_W-31){1'b0}}, amt};
        ords  = (full && lent_reg.orders != '0) ? lent_reg.orders - 1'b1 : lent_reg.orders;
        empty = (tot == '0) && (ords == '0);
        base  = lfound_reg ? lent_reg : '0;

        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg < obt_pkg::CLR_W'(obt_pkg::ORDER_SLOTS - 1) ||
                    clr_reg == obt_pkg::CLR_W'(obt_pkg::ORDER_SLOTS - 1))
                begin
                    ord_we    = 1'b1;
                    ord_waddr = clr_reg[OIDX_W-1:0];
                    ord_wdata = '0;
                end
                if (clr_reg < obt_pkg::CLR_W'(2 * obt_pkg::LEVEL_SLOTS - 1) ||
                    clr_reg == obt_pkg::CLR_W'(2 * obt_pkg::LEVEL_SLOTS - 1))
                begin
                    lvl_we    = 1'b1;
                    lvl_waddr = clr_reg[LADDR_W-1:0];
                    lvl_wdata = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == obt_pkg::CLR_W'(obt_pkg::CLEAR_LEN - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop          = 1'b1;
                    cmd_next         = cmd;
                    ovf_next         = 1'b0;
                    oidx_next        = '0;
                    ofound_next      = 1'b0;
                    ofree_found_next = 1'b0;
                    state_next = (cmd.kind == obt_pkg::KIND_NONE) ? S_DONE : S_ORD_RD;
                end
            end
            S_ORD_RD:
            begin
                state_next = S_ORD_CMP;
            end
            S_ORD_CMP:
            begin
                if (ord_rd_reg.valid && ord_rd_reg.key == cmd_reg.order_ref && !ofound_reg)
                begin
                    ofound_next = 1'b1;
                    omatch_next = oidx_reg;
                    oent_next   = ord_rd_reg;
                end
                if (!ord_rd_reg.valid && !ofree_found_reg)
                begin
                    ofree_found_next = 1'b1;
                    ofree_next       = oidx_reg;
                end
                oidx_next = oidx_reg + 1'b1;
                if (oidx_reg == OIDX_W'(obt_pkg::ORDER_SLOTS - 1))
                    state_next = S_ORD_END;
                else
                    state_next = S_ORD_RD;
            end
            S_ORD_END:
            begin
                lidx_next        = '0;
                lfound_next      = 1'b0;
                lfree_found_next = 1'b0;
                if (ofound_reg)
                begin
                    lside_next  = oent_reg.side;
                    lprice_next = oent_reg.price;
                    lnew_next   = 1'b0;
                    state_next  = S_LVL_RD;
                end
                else if (cmd_reg.kind == obt_pkg::KIND_NEW)
                    state_next = S_NEW_CHK;
                else
                    state_next = S_DONE;
            end
            S_LVL_RD:
            begin
                state_next = S_LVL_CMP;
            end
            S_LVL_CMP:
            begin
                if (lvl_rd_reg.valid && lvl_rd_reg.price == lprice_reg && !lfound_reg)
                begin
                    lfound_next = 1'b1;
                    lmatch_next = lidx_reg;
                    lent_next   = lvl_rd_reg;
                end
                if (!lvl_rd_reg.valid && !lfree_found_reg)
                begin
                    lfree_found_next = 1'b1;
                    lfree_next       = lidx_reg;
                end
                lidx_next = lidx_reg + 1'b1;
                if (lidx_reg == LIDX_W'(obt_pkg::LEVEL_SLOTS - 1))
                    state_next = lnew_reg ? S_INSERT : S_REDUCE;
                else
                    state_next = S_LVL_RD;
            end
            S_REDUCE:
            begin
                ord_we = 1'b1;
                if (!lfound_reg || full)
                begin
                    // order leaves the book
                    ord_wdata.valid = 1'b0;
                    if (live_reg != '0)
                        live_next = live_reg - 1'b1;
                end
                else
                    ord_wdata.remaining = oent_reg.remaining - amt;
                if (lfound_reg)
                begin
                    lvl_we           = 1'b1;
                    lvl_wdata.total  = tot;
                    lvl_wdata.orders = ords;
                    if (empty)
                    begin
                        lvl_wdata.valid = 1'b0;
                        if (lside_reg)
                        begin
                            if (ask_reg != '0)
                                ask_next = ask_reg - 1'b1;
                        end
                        else if (bid_reg != '0)
                            bid_next = bid_reg - 1'b1;
                    end
                end
                state_next = (cmd_reg.kind == obt_pkg::KIND_NEW) ? S_NEW_CHK : S_DONE;
            end
            S_NEW_CHK:
            begin
                if (!ofound_reg && !ofree_found_reg)
                begin
                    ovf_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    // a replaced order frees its slot, which may sit lower
                    if (ofound_reg && (!ofree_found_reg || omatch_reg < ofree_reg))
                        slot_next = omatch_reg;
                    else
                        slot_next = ofree_reg;
                    lside_next       = cmd_reg.side;
                    lprice_next      = cmd_reg.price;
                    lnew_next        = 1'b1;
                    lidx_next        = '0;
                    lfound_next      = 1'b0;
                    lfree_found_next = 1'b0;
                    state_next       = S_LVL_RD;
                end
            end
            S_INSERT:
            begin
                if (lfound_reg || lfree_found_reg)
                begin
                    lvl_we           = 1'b1;
                    lvl_waddr        = {lside_reg, lfound_reg ? lmatch_reg : lfree_reg};
                    lvl_wdata.valid  = 1'b1;
                    lvl_wdata.price  = cmd_reg.price;
                    lvl_wdata.total  = base.total +
                                       {{(obt_pkg::TOTAL_W-31){1'b0}}, cmd_reg.amount};
                    lvl_wdata.orders = base.orders + 1'b1;
                    if (!lfound_reg)
                    begin
                        if (lside_reg)
                            ask_next = ask_reg + 1'b1;
                        else
                            bid_next = bid_reg + 1'b1;
                    end
                    ord_we              = 1'b1;
                    ord_waddr           = slot_reg;
                    ord_wdata.valid     = 1'b1;
                    ord_wdata.key       = cmd_reg.order_ref;
                    ord_wdata.price     = cmd_reg.price;
                    ord_wdata.remaining = cmd_reg.amount;
                    ord_wdata.side      = cmd_reg.side;
                    live_next           = live_reg + 1'b1;
                end
                else
                    ovf_next = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    peak_ord_next  = (live_reg > peak_ord_reg) ? live_reg : peak_ord_reg;
                    peak_lvl_next  = (most > peak_lvl_reg) ? most : peak_lvl_reg;
                    out_valid_next = 1'b1;
                    out_item_next.active_orders   = live_reg;
                    out_item_next.bid_level_count = bid_reg;
                    out_item_next.ask_level_count = ask_reg;
                    out_item_next.peak_orders     = peak_ord_next;
                    out_item_next.peak_levels     = peak_lvl_next;
                    out_item_next.overflow        = ovf_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            live_reg      <= '0;
            bid_reg       <= '0;
            ask_reg       <= '0;
            peak_ord_reg  <= '0;
            peak_lvl_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            live_reg      <= live_next;
            bid_reg       <= bid_next;
            ask_reg       <= ask_next;
            peak_ord_reg  <= peak_ord_next;
            peak_lvl_reg  <= peak_lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        oidx_reg        <= oidx_next;
        omatch_reg      <= omatch_next;
        ofree_reg       <= ofree_next;
        slot_reg        <= slot_next;
        ofound_reg      <= ofound_next;
        ofree_found_reg <= ofree_found_next;
        oent_reg        <= oent_next;
        lidx_reg        <= lidx_next;
        lmatch_reg      <= lmatch_next;
        lfree_reg       <= lfree_next;
        lfound_reg      <= lfound_next;
        lfree_found_reg <= lfree_found_next;
        lent_reg        <= lent_next;
        lside_reg       <= lside_next;
        lnew_reg        <= lnew_next;
        lprice_reg      <= lprice_next;
        ovf_reg         <= ovf_next;
        out_item_reg    <= out_item_next;
    end

    // order and level tables, one read and one write port each
    always_ff @(posedge clk)
    begin
        ord_rd_reg <= ord_mem[ord_raddr];
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
    end

    always_ff @(posedge clk)
    begin
        lvl_rd_reg <= lvl_mem[lvl_raddr];
        if (lvl_we)
            lvl_mem[lvl_waddr] <= lvl_wdata;
    end

endmodule

@@ design/order_book_level_tracker.sv @@
// Order book level tracker: front classifier, command queue and table engine.
// Flow: an ignored message goes from idle straight to the result register;
// others scan the order table entry by entry (read, then compare), then up to
// two level-side scans, each entry read then compared, before the update.
// The back end takes a new command only after the current result is registered.
// Reset: a clearing pass over both tables runs first.
module order_book_level_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  obt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output obt_pkg::out_item_t out_item
);

    logic          cmd_valid;
    logic          cmd_pop;
    obt_pkg::cmd_t cmd;

    // front: takes beats while the back end is busy with a scan, until its queue is full
    obt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // back: table lookups, updates and the result register
    obt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
